### src/msp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI stream parser package
// Field widths, event kinds and MIDI status codes shared by the parser core
// and its channel interfaces.
// ----------------------------------------------------------------------------
package msp_pkg;

   localparam int NUM_CHANNELS_DEF = 16;

   localparam int BYTE_W  = 8;
   localparam int KIND_W  = 5;
   localparam int CHAN_W  = 4;
   localparam int INDEX_W = 7;
   localparam int VALUE_W = 14;
   localparam int DATA_W  = 7;

   // Event kinds reported on the result channel.
   localparam logic [KIND_W-1:0] KIND_KEY        = 5'd0;
   localparam logic [KIND_W-1:0] KIND_VELOCITY   = 5'd1;
   localparam logic [KIND_W-1:0] KIND_KEY_PRESS  = 5'd2;
   localparam logic [KIND_W-1:0] KIND_CONTROL    = 5'd3;
   localparam logic [KIND_W-1:0] KIND_PROGRAM    = 5'd4;
   localparam logic [KIND_W-1:0] KIND_CHAN_PRESS = 5'd5;
   localparam logic [KIND_W-1:0] KIND_BEND       = 5'd6;
   localparam logic [KIND_W-1:0] KIND_MTC        = 5'd7;
   localparam logic [KIND_W-1:0] KIND_SONG_POS   = 5'd8;
   localparam logic [KIND_W-1:0] KIND_SONG_SEL   = 5'd9;
   localparam logic [KIND_W-1:0] KIND_TUNE       = 5'd10;
   localparam logic [KIND_W-1:0] KIND_CLOCK      = 5'd11;
   localparam logic [KIND_W-1:0] KIND_START      = 5'd12;
   localparam logic [KIND_W-1:0] KIND_CONTINUE   = 5'd13;
   localparam logic [KIND_W-1:0] KIND_STOP       = 5'd14;
   localparam logic [KIND_W-1:0] KIND_SENSING    = 5'd15;
   localparam logic [KIND_W-1:0] KIND_RESET      = 5'd16;
   localparam logic [KIND_W-1:0] KIND_SYSEX_DONE = 5'd17;
   localparam logic [KIND_W-1:0] KIND_ERROR      = 5'd18;

   // Channel message types (upper nibble of the status byte).
   localparam logic [3:0] MSG_NOTE_OFF   = 4'h8;
   localparam logic [3:0] MSG_NOTE_ON    = 4'h9;
   localparam logic [3:0] MSG_KEY_PRESS  = 4'hA;
   localparam logic [3:0] MSG_CONTROL    = 4'hB;
   localparam logic [3:0] MSG_PROGRAM    = 4'hC;
   localparam logic [3:0] MSG_CHAN_PRESS = 4'hD;
   localparam logic [3:0] MSG_BEND       = 4'hE;

   // System bytes.
   localparam logic [BYTE_W-1:0] STATUS_NONE  = 8'h00;
   localparam logic [BYTE_W-1:0] STATUS_FIRST = 8'h80;
   localparam logic [BYTE_W-1:0] SYS_SYSEX    = 8'hF0;
   localparam logic [BYTE_W-1:0] SYS_MTC      = 8'hF1;
   localparam logic [BYTE_W-1:0] SYS_SONG_POS = 8'hF2;
   localparam logic [BYTE_W-1:0] SYS_SONG_SEL = 8'hF3;
   localparam logic [BYTE_W-1:0] SYS_TUNE     = 8'hF6;
   localparam logic [BYTE_W-1:0] SYS_EOX      = 8'hF7;
   localparam logic [BYTE_W-1:0] RT_CLOCK     = 8'hF8;
   localparam logic [BYTE_W-1:0] RT_START     = 8'hFA;
   localparam logic [BYTE_W-1:0] RT_CONTINUE  = 8'hFB;
   localparam logic [BYTE_W-1:0] RT_STOP      = 8'hFC;
   localparam logic [BYTE_W-1:0] RT_SENSING   = 8'hFE;
   localparam logic [BYTE_W-1:0] RT_RESET     = 8'hFF;

endpackage

`default_nettype wire

### src/msp_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI byte channel
// Valid/ready channel that carries one received MIDI byte per word.
// ----------------------------------------------------------------------------
interface msp_req_if;
   import msp_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] midi_byte;

   modport source (output valid, output midi_byte, input ready);
   modport sink   (input valid, input midi_byte, output ready);

endinterface

`default_nettype wire

### src/msp_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI event channel
// Valid/ready channel that carries one parsed MIDI event per word.
// ----------------------------------------------------------------------------
interface msp_rsp_if;
   import msp_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  event_kind;
   logic [CHAN_W-1:0]  channel_number;
   logic [INDEX_W-1:0] item_index;
   logic [VALUE_W-1:0] event_value;
   logic               last_of_run;

   modport source (output valid, output event_kind, output channel_number,
                   output item_index, output event_value, output last_of_run,
                   input ready);
   modport sink   (input valid, input event_kind, input channel_number,
                   input item_index, input event_value, input last_of_run,
                   output ready);

endinterface

`default_nettype wire

### src/midi_stream_parser_change_filter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// MIDI stream parser with change filter
// Assembles MIDI messages with running status and reports only stored values
// that change, plus system common, real-time, sysex-end and error events.
// ----------------------------------------------------------------------------
// After reset the block sweeps its key store once, one entry per cycle, and
// takes no byte until the sweep has ended. Then it takes one byte per cycle:
// the byte is parsed in the cycle it is accepted, the key store is read at
// that edge, and in the next cycle the compare and write-back run and up to
// two events are pushed into an eight-word result queue. An event reaches
// the result channel after the compare-stage registers and the queue. Results
// leave at one word per cycle while the result side is ready. Only the last
// data byte of a note message can give two events, and it always follows a
// data byte that gives none, so with the result side ready the block keeps up
// with one byte per cycle. Input stalls only while the queue lacks room for
// the words of the byte in the compare stage and of the next byte.
// ----------------------------------------------------------------------------
module midi_stream_parser_change_filter_core #(
   parameter int NUM_CHANNELS = msp_pkg::NUM_CHANNELS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   msp_req_if.sink      req_chan,
   msp_rsp_if.source    rsp_chan
);
   import msp_pkg::*;

   localparam int KEYS     = NUM_CHANNELS * 128;
   localparam int KEY_W    = $clog2(KEYS);
   localparam int CH_IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int FIFO_DEPTH = 8;
   localparam int PTR_W    = $clog2(FIFO_DEPTH);
   localparam int CNT_W    = PTR_W + 1;

   typedef struct packed {
      logic              down;
      logic [DATA_W-1:0] velocity;
      logic [DATA_W-1:0] pressure;
      logic [DATA_W-1:0] control;
   } key_entry_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  channel;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               last;
   } event_word_type;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_EVENT,
      OP_CHANNEL
   } op_type;

   // Key store and its clearing sweep.
   key_entry_type     key_mem [KEYS];
   key_entry_type     mem_rd_ff;
   logic              clearing_ff;
   logic [KEY_W-1:0]  clr_idx_ff;

   // Per-channel stores.
   logic [DATA_W-1:0]  program_ff    [NUM_CHANNELS];
   logic [DATA_W-1:0]  chan_press_ff [NUM_CHANNELS];
   logic [VALUE_W-1:0] bend_ff       [NUM_CHANNELS];

   // Parser state.
   logic [BYTE_W-1:0] status_ff, status_in;
   logic              have_first_ff, have_first_in;
   logic [DATA_W-1:0] first_ff, first_in;
   logic              sysex_ff, sysex_in;

   // Parse results for the incoming byte.
   op_type             p_op;
   logic [KIND_W-1:0]  p_kind;
   logic [INDEX_W-1:0] p_index;
   logic [VALUE_W-1:0] p_value;
   logic [DATA_W-1:0]  p_d1;
   logic [10:0]        p_addr_full;
   logic [KEY_W-1:0]   p_addr;
   logic [BYTE_W-1:0]  in_byte;
   logic               is_two;
   logic               accept;

   // Compare stage.
   op_type             s1_op_ff;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [3:0]         s1_msg_ff;
   logic [CHAN_W-1:0]  s1_ch_ff;
   logic [DATA_W-1:0]  s1_d1_ff;
   logic [DATA_W-1:0]  s1_d2_ff;
   logic [KEY_W-1:0]   s1_addr_ff;

   logic [CH_IDX_W-1:0] s1_chn;
   key_entry_type       new_entry;
   logic                mem_we;
   logic                prog_we;
   logic                press_we;
   logic                bend_we;
   logic [VALUE_W-1:0]  bend_value;
   logic                chg_key;
   logic                chg_vel;
   logic                key_down;
   event_word_type      res_a;
   event_word_type      res_b;
   logic [1:0]          res_n;

   // Result queue.
   event_word_type    fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              pop;
   logic [CNT_W:0]    reserve;

   // ------------------------------------------------------------------------
   // Handshake
   // ------------------------------------------------------------------------
   // Room is kept for two words from the byte in the compare stage and two
   // from the byte that would be accepted now.
   assign reserve        = {1'b0, count_ff} + ((s1_op_ff != OP_NONE) ? (CNT_W+1)'(2)
                                                                      : (CNT_W+1)'(0));
   assign req_chan.ready = !clearing_ff && (reserve <= (CNT_W+1)'(FIFO_DEPTH - 2));
   assign accept         = req_chan.valid && req_chan.ready;
   assign in_byte        = req_chan.midi_byte;

   // ------------------------------------------------------------------------
   // Byte parser
   // ------------------------------------------------------------------------
   assign is_two = (status_ff == SYS_SONG_POS) || (status_ff[7:4] == MSG_NOTE_OFF) ||
                   (status_ff[7:4] == MSG_NOTE_ON) || (status_ff[7:4] == MSG_KEY_PRESS) ||
                   (status_ff[7:4] == MSG_CONTROL) || (status_ff[7:4] == MSG_BEND);
   assign p_d1        = is_two ? first_ff : in_byte[DATA_W-1:0];
   assign p_addr_full = {status_ff[3:0], p_d1};
   assign p_addr      = p_addr_full[KEY_W-1:0];

   always_comb begin
      status_in     = status_ff;
      have_first_in = have_first_ff;
      first_in      = first_ff;
      sysex_in      = sysex_ff;
      p_op          = OP_NONE;
      p_kind        = KIND_ERROR;
      p_index       = '0;
      p_value       = '0;
      priority if (in_byte >= RT_CLOCK) begin
         p_op = OP_EVENT;
         unique case (in_byte)
            RT_CLOCK:    p_kind = KIND_CLOCK;
            RT_START:    p_kind = KIND_START;
            RT_CONTINUE: p_kind = KIND_CONTINUE;
            RT_STOP:     p_kind = KIND_STOP;
            RT_SENSING:  p_kind = KIND_SENSING;
            RT_RESET:    p_kind = KIND_RESET;
            default: begin
               // Undefined real-time codes are silently skipped inside sysex.
               if (sysex_ff) begin
                  p_op = OP_NONE;
               end else begin
                  status_in     = STATUS_NONE;
                  have_first_in = 1'b0;
               end
            end
         endcase
      end else if (sysex_ff) begin
         if (in_byte == SYS_EOX) begin
            sysex_in = 1'b0;
            p_op     = OP_EVENT;
            p_kind   = KIND_SYSEX_DONE;
         end
      end else if (in_byte >= STATUS_FIRST) begin
         have_first_in = 1'b0;
         if (in_byte < SYS_SYSEX) begin
            status_in = in_byte;
         end else begin
            unique case (in_byte)
               SYS_SYSEX: begin
                  status_in = STATUS_NONE;
                  sysex_in  = 1'b1;
               end
               SYS_MTC, SYS_SONG_POS, SYS_SONG_SEL: status_in = in_byte;
               SYS_TUNE: begin
                  status_in = STATUS_NONE;
                  p_op      = OP_EVENT;
                  p_kind    = KIND_TUNE;
               end
               default: begin
                  status_in = STATUS_NONE;
                  p_op      = OP_EVENT;
               end
            endcase
         end
      end else if (status_ff == STATUS_NONE) begin
         have_first_in = 1'b0;
         p_op          = OP_EVENT;
      end else if (is_two && !have_first_ff) begin
         first_in      = in_byte[DATA_W-1:0];
         have_first_in = 1'b1;
      end else begin
         have_first_in = 1'b0;
         priority if (status_ff == SYS_MTC) begin
            status_in = STATUS_NONE;
            p_op      = OP_EVENT;
            p_kind    = KIND_MTC;
            p_index   = {4'd0, in_byte[6:4]};
            p_value   = {10'd0, in_byte[3:0]};
         end else if (status_ff == SYS_SONG_POS) begin
            status_in = STATUS_NONE;
            p_op      = OP_EVENT;
            p_kind    = KIND_SONG_POS;
            p_value   = {in_byte[DATA_W-1:0], p_d1};
         end else if (status_ff == SYS_SONG_SEL) begin
            status_in = STATUS_NONE;
            p_op      = OP_EVENT;
            p_kind    = KIND_SONG_SEL;
            p_value   = {7'd0, in_byte[DATA_W-1:0]};
         end else if (int'(status_ff[3:0]) < NUM_CHANNELS) begin
            p_op = OP_CHANNEL;
         end else begin
            // A channel beyond the configured count is parsed but ignored.
            p_op = OP_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff     <= STATUS_NONE;
         have_first_ff <= 1'b0;
         first_ff      <= '0;
         sysex_ff      <= 1'b0;
         s1_op_ff      <= OP_NONE;
      end else begin
         if (accept) begin
            status_ff     <= status_in;
            have_first_ff <= have_first_in;
            first_ff      <= first_in;
            sysex_ff      <= sysex_in;
            s1_op_ff      <= p_op;
         end else begin
            s1_op_ff <= OP_NONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= p_kind;
      s1_index_ff <= p_index;
      s1_value_ff <= p_value;
      s1_msg_ff   <= status_ff[7:4];
      s1_ch_ff    <= status_ff[3:0];
      s1_d1_ff    <= p_d1;
      s1_d2_ff    <= in_byte[DATA_W-1:0];
      s1_addr_ff  <= p_addr;
   end

   // ------------------------------------------------------------------------
   // Key store: read at accept, compare and write back in the next cycle.
   // A key message needs two data bytes, so the next key read always comes
   // after the write-back and never sees a stale entry.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         key_mem[clr_idx_ff] <= '0;
      end else if (mem_we) begin
         key_mem[s1_addr_ff] <= new_entry;
      end
      mem_rd_ff <= key_mem[p_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clearing_ff) begin
         clr_idx_ff <= clr_idx_ff + KEY_W'(1);
         if (clr_idx_ff == KEY_W'(KEYS - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Compare stage
   // ------------------------------------------------------------------------
   assign s1_chn     = s1_ch_ff[CH_IDX_W-1:0];
   assign bend_value = {s1_d2_ff, s1_d1_ff};
   assign key_down   = (s1_msg_ff == MSG_NOTE_ON) && (s1_d2_ff != '0);
   assign chg_key    = mem_rd_ff.down != key_down;
   assign chg_vel    = mem_rd_ff.velocity != s1_d2_ff;

   always_comb begin
      new_entry = mem_rd_ff;
      mem_we    = 1'b0;
      prog_we   = 1'b0;
      press_we  = 1'b0;
      bend_we   = 1'b0;
      res_n     = 2'd0;
      res_a     = '{kind: s1_kind_ff, channel: '0, index: s1_index_ff,
                    value: s1_value_ff, last: 1'b1};
      res_b     = '{kind: KIND_VELOCITY, channel: s1_ch_ff, index: s1_d1_ff,
                    value: {7'd0, s1_d2_ff}, last: 1'b1};
      unique case (s1_op_ff)
         OP_NONE: res_n = 2'd0;
         OP_EVENT: res_n = 2'd1;
         OP_CHANNEL: begin
            res_a.channel = s1_ch_ff;
            res_a.index   = '0;
            res_a.value   = {7'd0, s1_d2_ff};
            unique case (s1_msg_ff)
               MSG_NOTE_OFF, MSG_NOTE_ON: begin
                  mem_we             = 1'b1;
                  new_entry.down     = key_down;
                  new_entry.velocity = s1_d2_ff;
                  res_a.index        = s1_d1_ff;
                  if (chg_key) begin
                     res_a.kind  = KIND_KEY;
                     res_a.value = {13'd0, key_down};
                     res_a.last  = !chg_vel;
                     res_n       = chg_vel ? 2'd2 : 2'd1;
                  end else if (chg_vel) begin
                     res_a.kind = KIND_VELOCITY;
                     res_n      = 2'd1;
                  end
               end
               MSG_KEY_PRESS: begin
                  mem_we             = 1'b1;
                  new_entry.pressure = s1_d2_ff;
                  res_a.kind         = KIND_KEY_PRESS;
                  res_a.index        = s1_d1_ff;
                  res_n = (mem_rd_ff.pressure != s1_d2_ff) ? 2'd1 : 2'd0;
               end
               MSG_CONTROL: begin
                  mem_we            = 1'b1;
                  new_entry.control = s1_d2_ff;
                  res_a.kind        = KIND_CONTROL;
                  res_a.index       = s1_d1_ff;
                  res_n = (mem_rd_ff.control != s1_d2_ff) ? 2'd1 : 2'd0;
               end
               MSG_PROGRAM: begin
                  prog_we    = 1'b1;
                  res_a.kind = KIND_PROGRAM;
                  res_n = (program_ff[s1_chn] != s1_d2_ff) ? 2'd1 : 2'd0;
               end
               MSG_CHAN_PRESS: begin
                  press_we   = 1'b1;
                  res_a.kind = KIND_CHAN_PRESS;
                  res_n = (chan_press_ff[s1_chn] != s1_d2_ff) ? 2'd1 : 2'd0;
               end
               MSG_BEND: begin
                  bend_we     = 1'b1;
                  res_a.kind  = KIND_BEND;
                  res_a.value = bend_value;
                  res_n = (bend_ff[s1_chn] != bend_value) ? 2'd1 : 2'd0;
               end
               default: res_n = 2'd0;
            endcase
         end
         default: res_n = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            program_ff[c]    <= '0;
            chan_press_ff[c] <= '0;
            bend_ff[c]       <= '0;
         end
      end else begin
         if (prog_we) begin
            program_ff[s1_chn] <= s1_d2_ff;
         end
         if (press_we) begin
            chan_press_ff[s1_chn] <= s1_d2_ff;
         end
         if (bend_we) begin
            bend_ff[s1_chn] <= bend_value;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------------
   assign pop = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (res_n != 2'd0) begin
         fifo_ff[wr_ptr_ff] <= res_a;
      end
      if (res_n == 2'd2) begin
         fifo_ff[wr_ptr_ff + PTR_W'(1)] <= res_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff + PTR_W'(res_n);
         rd_ptr_ff <= rd_ptr_ff + PTR_W'(pop);
         count_ff  <= count_ff + CNT_W'(res_n) - CNT_W'(pop);
      end
   end

   assign rsp_chan.valid          = count_ff != '0;
   assign rsp_chan.event_kind     = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.channel_number = fifo_ff[rd_ptr_ff].channel;
   assign rsp_chan.item_index     = fifo_ff[rd_ptr_ff].index;
   assign rsp_chan.event_value    = fifo_ff[rd_ptr_ff].value;
   assign rsp_chan.last_of_run    = fifo_ff[rd_ptr_ff].last;

endmodule

`default_nettype wire

### tb/sv/msp_event_checker.sv
// ----------------------------------------------------------------------------
// MIDI parser event checker
// Watches the byte and event channels of the parser core, predicts the events
// of every accepted byte from its own copy of the parser state and the value
// stores, and compares every accepted event word against the oldest
// prediction.
// ----------------------------------------------------------------------------
module msp_event_checker #(
   parameter int NUM_CHANNELS = msp_pkg::NUM_CHANNELS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   msp_req_if                     req_chan,
   msp_rsp_if                     rsp_chan,
   output int unsigned            mismatch_count,
   output int unsigned            pending_count,
   output int unsigned            bytes_seen,
   output int unsigned            events_seen,
   output int unsigned            error_events,
   output logic [msp_pkg::KIND_ERROR:0] kinds_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import msp_pkg::*;

   localparam int KEY_SLOTS = NUM_CHANNELS * 128;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [CHAN_W-1:0]  chan;
      logic [INDEX_W-1:0] index;
      logic [VALUE_W-1:0] value;
      logic               last;
   } midi_event_type;

   // Value stores, one slot per channel and key or controller.
   bit                 key_down       [KEY_SLOTS];
   logic [DATA_W-1:0]  velocity_mem   [KEY_SLOTS];
   logic [DATA_W-1:0]  key_press_mem  [KEY_SLOTS];
   logic [DATA_W-1:0]  control_mem    [KEY_SLOTS];
   logic [DATA_W-1:0]  program_mem    [NUM_CHANNELS];
   logic [DATA_W-1:0]  chan_press_mem [NUM_CHANNELS];
   logic [VALUE_W-1:0] bend_mem       [NUM_CHANNELS];

   // Message assembly state.
   logic [BYTE_W-1:0]  status_hold;
   logic [1:0]         data_held;
   logic [DATA_W-1:0]  first_data;
   bit                 sysex_open;

   midi_event_type expected_events [$];
   midi_event_type byte_events [$];

   task automatic clear_state();
      for (int i = 0; i < KEY_SLOTS; i++) begin
         key_down[i]      = 1'b0;
         velocity_mem[i]  = '0;
         key_press_mem[i] = '0;
         control_mem[i]   = '0;
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         program_mem[i]    = '0;
         chan_press_mem[i] = '0;
         bend_mem[i]       = '0;
      end
      status_hold = STATUS_NONE;
      data_held   = '0;
      first_data  = '0;
      sysex_open  = 1'b0;
      expected_events.delete();
      mismatch_count = 0;
      bytes_seen     = 0;
      events_seen    = 0;
      error_events   = 0;
      kinds_seen     = '0;
   endtask

   // A byte never gives more than two events.
   task automatic add_event(input logic [KIND_W-1:0] kind, input logic [CHAN_W-1:0] chan,
                            input logic [INDEX_W-1:0] index, input logic [VALUE_W-1:0] value);
      midi_event_type ev;
      ev.kind  = kind;
      ev.chan  = chan;
      ev.index = index;
      ev.value = value;
      ev.last  = 1'b0;
      if (byte_events.size() < 2)
         byte_events.insert(byte_events.size(), ev);
   endtask

   task automatic raise_error();
      status_hold = STATUS_NONE;
      data_held   = '0;
      add_event(KIND_ERROR, '0, '0, '0);
   endtask

   task automatic apply_channel(input logic [BYTE_W-1:0] st, input logic [DATA_W-1:0] d1,
                                input logic [DATA_W-1:0] d2);
      logic [CHAN_W-1:0]  ch;
      int                 slot;
      bit                 down;
      logic [VALUE_W-1:0] bend_value;
      ch = st[3:0];
      if (int'(ch) >= NUM_CHANNELS)
         return;
      slot = int'(ch) * 128 + int'(d1);
      case (st[7:4])
         MSG_NOTE_OFF, MSG_NOTE_ON: begin
            // A note on with zero velocity releases the key.
            down = (st[7:4] == MSG_NOTE_ON) && (d2 != 0);
            if (key_down[slot] != down) begin
               key_down[slot] = down;
               add_event(KIND_KEY, ch, d1, VALUE_W'(down));
            end
            if (velocity_mem[slot] != d2) begin
               velocity_mem[slot] = d2;
               add_event(KIND_VELOCITY, ch, d1, VALUE_W'(d2));
            end
         end
         MSG_KEY_PRESS: begin
            if (key_press_mem[slot] != d2) begin
               key_press_mem[slot] = d2;
               add_event(KIND_KEY_PRESS, ch, d1, VALUE_W'(d2));
            end
         end
         MSG_CONTROL: begin
            if (control_mem[slot] != d2) begin
               control_mem[slot] = d2;
               add_event(KIND_CONTROL, ch, d1, VALUE_W'(d2));
            end
         end
         MSG_PROGRAM: begin
            if (program_mem[ch] != d2) begin
               program_mem[ch] = d2;
               add_event(KIND_PROGRAM, ch, '0, VALUE_W'(d2));
            end
         end
         MSG_CHAN_PRESS: begin
            if (chan_press_mem[ch] != d2) begin
               chan_press_mem[ch] = d2;
               add_event(KIND_CHAN_PRESS, ch, '0, VALUE_W'(d2));
            end
         end
         default: begin
            bend_value = {d2, d1};
            if (bend_mem[ch] != bend_value) begin
               bend_mem[ch] = bend_value;
               add_event(KIND_BEND, ch, '0, bend_value);
            end
         end
      endcase
   endtask

   task automatic parse_midi_byte(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] st;
      bit                two;
      logic [DATA_W-1:0] d1;
      byte_events.delete();
      if (b >= RT_CLOCK) begin
         // Defined real-time bytes leave the assembly state alone.
         case (b)
            RT_CLOCK:    add_event(KIND_CLOCK, '0, '0, '0);
            RT_START:    add_event(KIND_START, '0, '0, '0);
            RT_CONTINUE: add_event(KIND_CONTINUE, '0, '0, '0);
            RT_STOP:     add_event(KIND_STOP, '0, '0, '0);
            RT_SENSING:  add_event(KIND_SENSING, '0, '0, '0);
            RT_RESET:    add_event(KIND_RESET, '0, '0, '0);
            default:     if (!sysex_open) raise_error();
         endcase
      end else if (sysex_open) begin
         if (b == SYS_EOX) begin
            sysex_open = 1'b0;
            add_event(KIND_SYSEX_DONE, '0, '0, '0);
         end
      end else if (b[7]) begin
         data_held = '0;
         if (b < SYS_SYSEX) begin
            status_hold = b;
         end else begin
            case (b)
               SYS_SYSEX: begin
                  status_hold = STATUS_NONE;
                  sysex_open  = 1'b1;
               end
               SYS_MTC, SYS_SONG_POS, SYS_SONG_SEL: status_hold = b;
               SYS_TUNE: begin
                  status_hold = STATUS_NONE;
                  add_event(KIND_TUNE, '0, '0, '0);
               end
               default: raise_error();
            endcase
         end
      end else if (status_hold == STATUS_NONE) begin
         raise_error();
      end else begin
         st  = status_hold;
         two = (st == SYS_SONG_POS) ||
               (st < SYS_SYSEX && st[7:4] != MSG_PROGRAM && st[7:4] != MSG_CHAN_PRESS);
         if (two && data_held == 0) begin
            first_data = b[6:0];
            data_held  = 2'd1;
         end else begin
            d1        = two ? first_data : b[6:0];
            data_held = '0;
            if (st == SYS_MTC) begin
               status_hold = STATUS_NONE;
               add_event(KIND_MTC, '0, INDEX_W'(b[6:4]), VALUE_W'(b[3:0]));
            end else if (st == SYS_SONG_POS) begin
               status_hold = STATUS_NONE;
               add_event(KIND_SONG_POS, '0, '0, {b[6:0], d1});
            end else if (st == SYS_SONG_SEL) begin
               status_hold = STATUS_NONE;
               add_event(KIND_SONG_SEL, '0, '0, VALUE_W'(b[6:0]));
            end else begin
               apply_channel(st, d1, b[6:0]);
            end
         end
      end
      if (byte_events.size() > 0)
         byte_events[byte_events.size() - 1].last = 1'b1;
      foreach (byte_events[i])
         expected_events.insert(expected_events.size(), byte_events[i]);
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_event();
      midi_event_type want;
      if (expected_events.size() == 0) begin
         $error("event word with nothing expected: kind %0d channel %0d index %0d value %0d",
                rsp_chan.event_kind, rsp_chan.channel_number, rsp_chan.item_index,
                rsp_chan.event_value);
         mismatch_count++;
      end else begin
         want = expected_events.pop_front();
         compare_field("event_kind", want.kind, rsp_chan.event_kind);
         compare_field("channel_number", want.chan, rsp_chan.channel_number);
         compare_field("item_index", want.index, rsp_chan.item_index);
         compare_field("event_value", want.value, rsp_chan.event_value);
         compare_field("last_of_run", want.last, rsp_chan.last_of_run);
      end
      events_seen++;
      if (rsp_chan.event_kind <= KIND_ERROR)
         kinds_seen[rsp_chan.event_kind] = 1'b1;
      if (rsp_chan.event_kind == KIND_ERROR)
         error_events++;
   endtask

   // Bytes are predicted before events are checked: an event never leaves in
   // the cycle its byte is taken, so the order only matters for the queue tail.
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            parse_midi_byte(req_chan.midi_byte);
            bytes_seen++;
         end
         if (rsp_chan.valid && rsp_chan.ready)
            check_event();
      end
      pending_count = expected_events.size();
   end

endmodule

### tb/sv/midi_stream_parser_change_filter_core_tb.sv
// ----------------------------------------------------------------------------
// MIDI stream parser testbench
// Feeds the parser core a directed byte sequence and then random MIDI traffic,
// mostly well-formed messages with and without running status, mixed with
// real-time bytes, sysex blocks, truncated messages and raw noise, while both
// channels stall at random. The event checker judges every event word.
// ----------------------------------------------------------------------------
module midi_stream_parser_change_filter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import msp_pkg::*;

   localparam int RANDOM_BYTES  = 700;
   localparam int IDLE_PERCENT  = 22;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 20;

   // Status bytes with no defined meaning.
   localparam logic [BYTE_W-1:0] SYS_UNDEF_LO = 8'hF4;
   localparam logic [BYTE_W-1:0] RT_UNDEF_LO  = 8'hF9;
   localparam logic [BYTE_W-1:0] RT_UNDEF_HI  = 8'hFD;

   localparam logic [BYTE_W-1:0] RT_BYTES [0:7] = '{
      RT_CLOCK, RT_START, RT_CONTINUE, RT_STOP, RT_SENSING, RT_RESET,
      RT_UNDEF_LO, RT_UNDEF_HI
   };

   localparam logic [BYTE_W-1:0] DIRECTED_BYTES [0:26] = '{
      8'h00,                                         // data with no status
      {MSG_NOTE_ON, 4'h0}, 8'h00, 8'h7F,             // key down, top velocity
      8'h00, 8'h00,                                  // running status, zero velocity
      {MSG_BEND, 4'hF}, 8'h7F, 8'h7F,                // largest bend, last channel
      {MSG_CONTROL, 4'hF}, 8'h7F, RT_START, 8'h40,   // real-time inside a message
      SYS_SYSEX, RT_UNDEF_LO, SYS_EOX,               // undefined byte skipped in sysex
      SYS_SONG_POS, 8'h00, 8'h7F,
      SYS_MTC, 8'h75,
      SYS_EOX,                                       // end of sysex outside sysex
      SYS_UNDEF_LO,
      {MSG_KEY_PRESS, 4'h5}, 8'h3C,                  // cut short by a new status
      {MSG_CHAN_PRESS, 4'h2}, 8'h11
   };

   logic        clock;
   logic        reset;
   bit          calm = 1'b0;
   int unsigned counted_bytes = 0;
   int unsigned cycle_count = 0;
   logic [BYTE_W-1:0] live_status = STATUS_NONE;

   int unsigned mismatch_count;
   int unsigned pending_count;
   int unsigned bytes_seen;
   int unsigned events_seen;
   int unsigned error_events;
   logic [KIND_ERROR:0] kinds_seen;

   msp_req_if req_chan ();
   msp_rsp_if rsp_chan ();

   midi_stream_parser_change_filter_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   msp_event_checker scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .bytes_seen     (bytes_seen),
      .events_seen    (events_seen),
      .error_events   (error_events),
      .kinds_seen     (kinds_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready = calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Called at a falling edge; returns at the falling edge after the word
   // is taken. Valid stays high between back-to-back words. Each idle cycle
   // is followed by another with the same odds, so the source idles in about
   // the same share of cycles as the sink.
   task automatic send_byte(input logic [BYTE_W-1:0] b, input bit counts = 1'b1);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid     = 1'b1;
      req_chan.midi_byte = b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (counts)
         counted_bytes++;
   endtask

   // Data bytes now and then have a real-time byte slipped in front of them.
   task automatic send_data(input logic [DATA_W-1:0] d);
      if ($urandom_range(99) < 6)
         send_byte(RT_BYTES[$urandom_range(7)]);
      send_byte({1'b0, d});
   endtask

   // Values lean on a few small numbers so that the change filter sees
   // repeats as well as changes.
   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(9))
         0, 1, 2: pick_value = DATA_W'($urandom_range(3));
         3:       pick_value = '0;
         4:       pick_value = 7'h7F;
         default: pick_value = DATA_W'($urandom_range(127));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_key();
      if ($urandom_range(99) < 70)
         pick_key = DATA_W'($urandom_range(7));
      else
         pick_key = DATA_W'($urandom_range(127));
   endfunction

   task automatic send_channel_message();
      logic [BYTE_W-1:0] status;
      bit                two;
      status = {4'($urandom_range(MSG_NOTE_OFF, MSG_BEND)), 4'($urandom_range(15))};
      if (live_status != STATUS_NONE && $urandom_range(99) < 40) begin
         status = live_status;
      end else begin
         send_byte(status);
         live_status = status;
      end
      two = status[7:4] != MSG_PROGRAM && status[7:4] != MSG_CHAN_PRESS;
      if (two) begin
         send_data(pick_key());
         if ($urandom_range(99) < 5)
            return;
      end
      send_data(pick_value());
   endtask

   task automatic send_system_common();
      case ($urandom_range(3))
         0: begin
            send_byte(SYS_MTC);
            send_data(DATA_W'($urandom_range(127)));
         end
         1: begin
            send_byte(SYS_SONG_POS);
            send_data(DATA_W'($urandom_range(127)));
            if ($urandom_range(99) < 90)
               send_data(DATA_W'($urandom_range(127)));
         end
         2: begin
            send_byte(SYS_SONG_SEL);
            send_data(DATA_W'($urandom_range(127)));
         end
         default: send_byte(SYS_TUNE);
      endcase
      live_status = STATUS_NONE;
   endtask

   // Payload data and status bytes are skipped by the block and do not count as items.
   task automatic send_sysex();
      send_byte(SYS_SYSEX);
      repeat ($urandom_range(5)) begin
         case ($urandom_range(9))
            0:       send_byte(RT_BYTES[$urandom_range(7)]);
            1:       send_byte(BYTE_W'($urandom_range(8'h80, 8'hF6)), 1'b0);
            default: send_byte(BYTE_W'($urandom_range(127)), 1'b0);
         endcase
      end
      send_byte(SYS_EOX);
      live_status = STATUS_NONE;
   endtask

   task automatic send_noise();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom());
      send_byte(b);
      if (b == SYS_SYSEX)
         send_byte(SYS_EOX);
      if (b[7] && b < SYS_SYSEX)
         live_status = b;
      else if (b[7] && b < RT_CLOCK)
         live_status = STATUS_NONE;
   endtask

   initial begin
      int unsigned pick;
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.midi_byte = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED_BYTES[i])
         send_byte(DIRECTED_BYTES[i]);

      while (counted_bytes < $size(DIRECTED_BYTES) + RANDOM_BYTES) begin
         // One stretch of the random traffic runs with no idling on either side.
         calm = counted_bytes >= $size(DIRECTED_BYTES) + 300 &&
                counted_bytes <  $size(DIRECTED_BYTES) + 450;
         pick = $urandom_range(99);
         if (pick < 60)
            send_channel_message();
         else if (pick < 72)
            send_system_common();
         else if (pick < 80)
            send_sysex();
         else if (pick < 88)
            send_byte(RT_BYTES[$urandom_range(7)]);
         else
            send_noise();
      end
      req_chan.valid = 1'b0;
      calm           = 1'b0;

      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d MIDI bytes and %0d event words, %0d of %0d event kinds.",
               bytes_seen, events_seen, $countones(kinds_seen), $bits(kinds_seen));
      $display("Parse errors reported: %0d; field mismatches: %0d.",
               error_events, mismatch_count);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
